FILE: rtl/buddy_page_allocator_macros.svh
// ----------------------------------------------------------------------------
// buddy page allocator assertion macros
// concurrent assertion wrappers, empty under synthesis
// ----------------------------------------------------------------------------
`ifndef BUDDY_PAGE_ALLOCATOR_MACROS_SVH
`define BUDDY_PAGE_ALLOCATOR_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define BPA_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("bpa check failed");
// next-cycle implication
`define BPA_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("bpa check failed");
`else
`define BPA_ASSERT_IMP(lbl, ante, cons)
`define BPA_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

FILE: rtl/bpa_pkg.sv
// ----------------------------------------------------------------------------
// bpa_pkg
// shared types, codes and helpers of the buddy page allocator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package bpa_pkg;

    localparam int ORD_W  = 4;
    localparam int HEAD_W = ORD_W + 1;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic ST_OK   = 1'b0;
    localparam logic ST_FAIL = 1'b1;

    typedef struct packed {
        logic        command;
        logic [9:0]  start_page;
        logic [10:0] page_count;
    } t_req;

    typedef struct packed {
        logic        status;
        logic [9:0]  granted_page;
        logic [10:0] pages_free;
    } t_rsp;

    // smallest order whose size covers the count, zero count as one page
    function automatic logic [ORD_W-1:0] order_for(input logic [10:0] cnt);
        logic [10:0]      v;
        logic [ORD_W-1:0] o;
        v = (cnt == 11'd0) ? 11'd0 : cnt - 11'd1;
        o = '0;
        for (int i = 0; i < 11; i++) begin
            if (v[i]) begin
                o = ORD_W'(i + 1);
            end
        end
        return o;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/bpa_ram.sv
// ----------------------------------------------------------------------------
// bpa_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module bpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire                       i_clk,
    input  wire                       i_we,
    input  wire [$clog2(DEPTH)-1:0]   i_waddr,
    input  wire [WIDTH-1:0]           i_wdata,
    input  wire                       i_re,
    input  wire [$clog2(DEPTH)-1:0]   i_raddr,
    output logic [WIDTH-1:0]          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

FILE: rtl/buddy_page_allocator.sv
// ----------------------------------------------------------------------------
// buddy_page_allocator
// power-of-two page allocator, block heads kept in one synchronous ram
// ----------------------------------------------------------------------------
//  channel | direction | handshake                | beat
//  in      | input     | i_in_valid / o_in_stall  | t_req: command, start, count
//  out     | output    | o_out_valid / i_out_stall| t_rsp: status, page, free
//
// one request at a time; an allocate scans the head ram one entry a cycle,
// then splits the block that it found; a free scans the same for overlap,
// then runs its merge steps
// after reset a clearing pass writes all POOL_PAGES entries, then the pool
// head; no request is taken meanwhile
// a finished beat sits in the output register; a new request is taken while
// it waits, the next result waits only for that register to drain
`timescale 1ns / 1ps
`default_nettype none
`include "buddy_page_allocator_macros.svh"
module buddy_page_allocator #(
    parameter int POOL_PAGES = 1024
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_in_valid,
    output logic             o_in_stall,
    input  bpa_pkg::t_req    i_in_data,
    output logic             o_out_valid,
    input  wire              i_out_stall,
    output bpa_pkg::t_rsp    o_out_data
);
    import bpa_pkg::*;

    localparam int AW = (POOL_PAGES > 1) ? $clog2(POOL_PAGES) : 1;
    // managed pool is the largest power of two not above POOL_PAGES
    localparam int PO = $clog2(POOL_PAGES + 1) - 1;
    localparam int PW = (AW + 2 > 13) ? AW + 2 : 13;
    localparam logic [PW-1:0]    POOL_SZ = PW'(2 ** PO);
    localparam logic [ORD_W-1:0] PO_ORD  = ORD_W'(PO);
    localparam logic [PW-1:0]    LAST_PG = PW'(POOL_PAGES - 1);

    typedef enum logic [13:0] {
        S_CLR   = 14'b00000000000001,
        S_INIT  = 14'b00000000000010,
        S_IDLE  = 14'b00000000000100,
        S_SCAN  = 14'b00000000001000,
        S_SPLIT = 14'b00000000010000,
        S_FWR   = 14'b00000000100000,
        S_MCHK  = 14'b00000001000000,
        S_MACK  = 14'b00000010000000,
        S_MAWR  = 14'b00000100000000,
        S_MBRD  = 14'b00001000000000,
        S_MBCK  = 14'b00010000000000,
        S_MBWR  = 14'b00100000000000,
        S_RESP  = 14'b01000000000000,
        S_HOLD  = 14'b10000000000000
    } t_state;

    t_state             r_state, n_state;
    logic               r_cmd, n_cmd;
    logic [9:0]         r_start, n_start;
    logic [ORD_W-1:0]   r_ord, n_ord;
    logic [ORD_W-1:0]   r_cur, n_cur;
    logic [PW-1:0]      r_size, n_size;
    logic [PW-1:0]      r_free, n_free;
    logic [PW-1:0]      r_p, n_p;
    logic [PW-1:0]      r_q, n_q;
    logic               r_qv, n_qv;
    logic [AW-1:0]      r_base, n_base;
    logic               r_merged, n_merged;
    logic               r_status, n_status;
    logic [AW-1:0]      r_grant, n_grant;
    logic               r_ovalid, n_ovalid;
    t_rsp               r_out, n_out;

    // head ram port
    logic               w_we;
    logic [AW-1:0]      w_waddr;
    logic [HEAD_W-1:0]  w_wdata;
    logic               w_re;
    logic [AW-1:0]      w_raddr;
    logic [HEAD_W-1:0]  w_rdata;

    // request decode
    logic [ORD_W-1:0]   w_req_ord;
    logic [PW-1:0]      w_req_size;
    logic [PW-1:0]      w_req_end;
    logic               w_accept;

    // scan / merge helpers
    logic [PW-1:0]      w_start_w;
    logic [PW-1:0]      w_end;
    logic [PW-1:0]      w_blk_end;
    logic               w_alloc_hit;
    logic               w_ovl_hit;
    logic [AW-1:0]      w_prev;
    logic [AW-1:0]      w_nxt;
    logic [PW-1:0]      w_nxt_w;
    logic [PW-1:0]      w_mask2;
    logic [HEAD_W-1:0]  w_head_o;
    logic [ORD_W-1:0]   w_cur_dn;
    logic [PW-1:0]      w_grant_w;

    bpa_ram #(
        .WIDTH (HEAD_W),
        .DEPTH (POOL_PAGES)
    ) u_heads (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign w_accept    = i_in_valid && !o_in_stall;
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

    assign w_req_ord  = order_for(i_in_data.page_count);
    assign w_req_size = PW'(1) << w_req_ord;
    assign w_req_end  = PW'(i_in_data.start_page) + w_req_size;

    assign w_start_w  = PW'(r_start);
    assign w_end      = w_start_w + r_size;
    assign w_blk_end  = r_q + (PW'(1) << w_rdata[ORD_W-1:0]);
    // first free head large enough
    assign w_alloc_hit = w_rdata[HEAD_W-1] && (w_rdata[ORD_W-1:0] >= r_ord);
    // freed range overlaps a free block
    assign w_ovl_hit   = w_rdata[HEAD_W-1] && (r_q < w_end) && (w_start_w < w_blk_end);

    assign w_prev    = r_base - r_size[AW-1:0];
    assign w_nxt_w   = PW'(r_base) + r_size;
    assign w_nxt     = w_nxt_w[AW-1:0];
    assign w_mask2   = (r_size << 1) - PW'(1);
    assign w_head_o  = {1'b1, r_ord};
    assign w_cur_dn  = r_cur - ORD_W'(1);
    assign w_grant_w = PW'(r_grant);

    always_comb begin
        n_state  = r_state;
        n_cmd    = r_cmd;
        n_start  = r_start;
        n_ord    = r_ord;
        n_cur    = r_cur;
        n_size   = r_size;
        n_free   = r_free;
        n_p      = r_p;
        n_q      = r_q;
        n_qv     = r_qv;
        n_base   = r_base;
        n_merged = r_merged;
        n_status = r_status;
        n_grant  = r_grant;
        n_ovalid = r_ovalid;
        n_out    = r_out;
        w_we     = 1'b0;
        w_waddr  = r_base;
        w_wdata  = '0;
        w_re     = 1'b0;
        w_raddr  = r_p[AW-1:0];

        // output register drains independently of the sequencer
        if (r_ovalid && !i_out_stall) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_CLR: begin
                // clearing pass over every head entry
                w_we    = 1'b1;
                w_waddr = r_p[AW-1:0];
                n_p     = r_p + PW'(1);
                if (r_p == LAST_PG) begin
                    n_state = S_INIT;
                end
            end
            S_INIT: begin
                // page zero heads the whole pool
                w_we    = 1'b1;
                w_waddr = '0;
                w_wdata = {1'b1, PO_ORD};
                n_state = S_IDLE;
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_cmd    = i_in_data.command;
                    n_start  = i_in_data.start_page;
                    n_ord    = w_req_ord;
                    n_size   = w_req_size;
                    n_p      = '0;
                    n_qv     = 1'b0;
                    n_status = ST_OK;
                    n_grant  = '0;
                    n_merged = 1'b0;
                    if (i_in_data.command == CMD_ALLOC) begin
                        if (w_req_size > r_free) begin
                            n_status = ST_FAIL;
                            n_state  = S_RESP;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end else begin
                        // oversized or out-of-pool free is dropped
                        if ((w_req_ord > PO_ORD) || (w_req_end > POOL_SZ)) begin
                            n_state = S_RESP;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end
                end
            end
            S_SCAN: begin
                // address issued in the cycle before its check
                if (r_p < POOL_SZ) begin
                    w_re = 1'b1;
                    n_p  = r_p + PW'(1);
                end
                n_q  = r_p;
                n_qv = (r_p < POOL_SZ);
                if (r_qv && (r_cmd == CMD_ALLOC) && w_alloc_hit) begin
                    n_base  = r_q[AW-1:0];
                    n_cur   = w_rdata[ORD_W-1:0];
                    n_state = S_SPLIT;
                end else if (r_qv && (r_cmd == CMD_FREE) && w_ovl_hit) begin
                    n_state = S_RESP;
                end else if (!r_qv && (r_p >= POOL_SZ)) begin
                    if (r_cmd == CMD_ALLOC) begin
                        n_status = ST_FAIL;
                        n_state  = S_RESP;
                    end else begin
                        n_state = S_FWR;
                    end
                end
            end
            S_SPLIT: begin
                if (r_cur > r_ord) begin
                    // upper half stays free
                    w_we    = 1'b1;
                    w_waddr = r_base + AW'(PW'(1) << w_cur_dn);
                    w_wdata = {1'b1, w_cur_dn};
                    n_cur   = w_cur_dn;
                end else begin
                    w_we    = 1'b1;
                    w_waddr = r_base;
                    w_wdata = '0;
                    n_free  = r_free - r_size;
                    n_grant = r_base;
                    n_state = S_RESP;
                end
            end
            S_FWR: begin
                w_we    = 1'b1;
                w_waddr = w_start_w[AW-1:0];
                w_wdata = w_head_o;
                n_base  = w_start_w[AW-1:0];
                n_free  = r_free + r_size;
                n_state = S_MCHK;
            end
            S_MCHK: begin
                n_merged = 1'b0;
                if (r_ord >= PO_ORD) begin
                    n_state = S_RESP;
                end else if (PW'(r_base) >= r_size) begin
                    w_re    = 1'b1;
                    w_raddr = w_prev;
                    n_state = S_MACK;
                end else begin
                    n_state = S_MBRD;
                end
            end
            S_MACK: begin
                // lower buddy
                if ((w_rdata == w_head_o) && ((PW'(w_prev) & w_mask2) == '0)) begin
                    w_we     = 1'b1;
                    w_waddr  = r_base;
                    w_wdata  = '0;
                    n_base   = w_prev;
                    n_ord    = r_ord + ORD_W'(1);
                    n_size   = r_size << 1;
                    n_merged = 1'b1;
                    n_state  = S_MAWR;
                end else begin
                    n_state = S_MBRD;
                end
            end
            S_MAWR: begin
                w_we    = 1'b1;
                w_waddr = r_base;
                w_wdata = w_head_o;
                n_state = S_MBRD;
            end
            S_MBRD: begin
                if (w_nxt_w < POOL_SZ) begin
                    w_re    = 1'b1;
                    w_raddr = w_nxt;
                    n_state = S_MBCK;
                end else begin
                    n_state = r_merged ? S_MCHK : S_RESP;
                end
            end
            S_MBCK: begin
                // upper buddy
                if ((w_rdata == w_head_o) && ((PW'(r_base) & w_mask2) == '0)) begin
                    w_we     = 1'b1;
                    w_waddr  = w_nxt;
                    w_wdata  = '0;
                    n_ord    = r_ord + ORD_W'(1);
                    n_size   = r_size << 1;
                    n_merged = 1'b1;
                    n_state  = S_MBWR;
                end else begin
                    n_state = r_merged ? S_MCHK : S_RESP;
                end
            end
            S_MBWR: begin
                w_we    = 1'b1;
                w_waddr = r_base;
                w_wdata = w_head_o;
                n_state = S_MCHK;
            end
            S_RESP: begin
                n_state = S_HOLD;
            end
            S_HOLD: begin
                // wait for the output register to be free
                if (!r_ovalid || !i_out_stall) begin
                    n_out.status       = r_status;
                    n_out.granted_page = w_grant_w[9:0];
                    n_out.pages_free   = r_free[10:0];
                    n_ovalid           = 1'b1;
                    n_state            = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_p      <= '0;
            r_qv     <= 1'b0;
            r_free   <= POOL_SZ;
            r_ovalid <= 1'b0;
            r_merged <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_p      <= n_p;
            r_qv     <= n_qv;
            r_free   <= n_free;
            r_ovalid <= n_ovalid;
            r_merged <= n_merged;
        end
        r_cmd    <= n_cmd;
        r_start  <= n_start;
        r_ord    <= n_ord;
        r_cur    <= n_cur;
        r_size   <= n_size;
        r_q      <= n_q;
        r_base   <= n_base;
        r_status <= n_status;
        r_grant  <= n_grant;
        r_out    <= n_out;
    end

    // free total never exceeds the managed pool
    `BPA_ASSERT_IMP(a_free_bound, 1'b1, r_free <= POOL_SZ)
    // a read never targets the entry being written in the same cycle
    `BPA_ASSERT_IMP(a_no_rw_clash, w_we && w_re, w_waddr != w_raddr)
    // a drained output register is loaded when a result leaves hold
    `BPA_ASSERT_NXT(a_result_out, (r_state == S_HOLD) && !r_ovalid, o_out_valid)
    // a granted block lies inside the managed pool
    `BPA_ASSERT_IMP(a_grant_in_pool, (r_state == S_SPLIT) && (r_cur <= r_ord), (PW'(r_base) + r_size) <= POOL_SZ)

endmodule
`default_nettype wire

FILE: tb/sv/buddy_page_allocator_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// buddy_page_allocator_checker
// watches both channels, models the buddy pool and compares every result beat
// ----------------------------------------------------------------------------
module buddy_page_allocator_checker #(
    parameter int POOL_PAGES = 1024
) (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_in_valid,
    input  wire            i_in_stall,
    input  bpa_pkg::t_req  i_in_data,
    input  wire            i_out_valid,
    input  wire            i_out_stall,
    input  bpa_pkg::t_rsp  i_out_data,
    output int             o_fail_count,
    output int             o_pending
);
    import bpa_pkg::*;

    localparam logic [4:0] FREE_BIT = 5'h10;

    logic [4:0]  heads [POOL_PAGES];
    int          model_free;
    int          pool_ord;
    t_rsp        expected_rsps [$];

    function automatic int round_order(input logic [10:0] cnt);
        int o;
        int c;
        o = 0;
        c = (cnt == 0) ? 1 : int'(cnt);
        while (o < 15 && (1 << o) < c) o++;
        return o;
    endfunction

    task automatic pool_reset();
        pool_ord = 0;
        while (pool_ord < 14 && (1 << (pool_ord + 1)) <= POOL_PAGES) pool_ord++;
        foreach (heads[i]) heads[i] = '0;
        heads[0] = FREE_BIT | 5'(pool_ord);
        model_free = 1 << pool_ord;
    endtask

    // apply one request to the pool model and return the expected beat
    function automatic t_rsp pool_apply(input t_req rq);
        t_rsp r;
        int   o, pool, sz, p, cur, hi, base, prv, nxt, st;
        bit   found, ok, merged;
        r = '0;
        pool = 1 << pool_ord;
        o = round_order(rq.page_count);
        st = int'(rq.start_page);
        if (rq.command == CMD_ALLOC) begin
            sz = 1 << o;
            found = 0;
            if (sz <= model_free) begin
                for (p = 0; p < pool; p++) begin
                    if (heads[p][4] && int'(heads[p][3:0]) >= o) begin
                        found = 1;
                        break;
                    end
                end
            end
            if (found) begin
                cur = heads[p][3:0];
                while (cur > o) begin
                    cur--;
                    hi = p + (1 << cur);
                    if (hi < pool) heads[hi] = FREE_BIT | 5'(cur);
                end
                heads[p] = '0;
                model_free -= sz;
                r.granted_page = 10'(p);
            end else begin
                r.status = ST_FAIL;
            end
        end else begin
            ok = (o <= pool_ord);
            sz = ok ? (1 << o) : 0;
            if (ok && st + sz > pool) ok = 0;
            if (ok) begin
                for (p = 0; p < pool; p++) begin
                    if (heads[p][4] && p < st + sz && st < p + (1 << heads[p][3:0])) begin
                        ok = 0;
                        break;
                    end
                end
            end
            if (ok) begin
                base = st;
                merged = 1;
                heads[base] = FREE_BIT | 5'(o);
                model_free += sz;
                while (merged && o < pool_ord) begin
                    merged = 0;
                    if (base >= sz) begin
                        prv = base - sz;
                        if (heads[prv] == (FREE_BIT | 5'(o)) && (prv & (2*sz - 1)) == 0) begin
                            heads[base] = '0;
                            base = prv;
                            o++;
                            sz <<= 1;
                            heads[base] = FREE_BIT | 5'(o);
                            merged = 1;
                        end
                    end
                    nxt = base + sz;
                    if (nxt < pool && heads[nxt] == (FREE_BIT | 5'(o))
                        && (base & (2*sz - 1)) == 0) begin
                        heads[nxt] = '0;
                        o++;
                        sz <<= 1;
                        heads[base] = FREE_BIT | 5'(o);
                        merged = 1;
                    end
                end
            end
        end
        r.pages_free = 11'(model_free);
        return r;
    endfunction

    assign o_pending = expected_rsps.size();

    always @(posedge i_clk) begin
        t_rsp e;
        if (!i_rst_n) begin
            pool_reset();
            expected_rsps.delete();
            o_fail_count <= 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_rsps.size() == 0) begin
                    if (o_fail_count < 10) $display("unexpected result beat %p", i_out_data);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    e = expected_rsps.pop_front();
                    if (e.status !== i_out_data.status
                        || e.granted_page !== i_out_data.granted_page
                        || e.pages_free !== i_out_data.pages_free) begin
                        if (o_fail_count < 10)
                            $display("mismatch: expected %p actual %p", e, i_out_data);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) expected_rsps.push_back(pool_apply(i_in_data));
        end
    end
endmodule

FILE: tb/sv/buddy_page_allocator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// buddy_page_allocator_tb
// drives directed and random alloc/free requests under varied idling; the
// checker predicts each result beat and counts mismatches
// ----------------------------------------------------------------------------
module buddy_page_allocator_tb;
    import bpa_pkg::*;

    logic  i_clk;
    logic  i_rst_n;
    logic  in_valid;
    logic  in_stall;
    t_req  in_data;
    logic  out_valid;
    logic  out_stall;
    t_rsp  out_data;
    int    fail_count;
    int    pending;
    int    cycle_count;
    int    send_idle_pct;
    int    recv_stall_pct;

    // blocks this side believes it holds, for well-formed frees
    logic [9:0]  held_start [$];
    logic [10:0] held_count [$];

    // last result beat seen on the output channel
    logic       chk_last_ok;
    logic [9:0] chk_last_page;

    buddy_page_allocator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    buddy_page_allocator_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // cycle watchdog; sized for the clearing pass, a full scan per item, long stalls
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 4000000) begin
            $display("FAIL");
            $finish;
        end
    end

    // receiver stall, reshuffled every cycle
    always @(posedge i_clk) begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (out_valid && !out_stall) begin
            chk_last_ok   <= (out_data.status == ST_OK);
            chk_last_page <= out_data.granted_page;
        end
    end

    // one beat: optional idle gap, then hold valid until accepted; valid is
    // left high so a following beat can go back to back
    task automatic send_beat(input logic cmd, input logic [9:0] st, input logic [10:0] cnt);
        if ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        in_data  <= '{command: cmd, start_page: st, page_count: cnt};
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
    endtask

    // wait for the result of an alloc and remember the block on success
    task automatic alloc_tracked(input logic [10:0] cnt);
        send_beat(CMD_ALLOC, 10'($urandom), cnt);
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending > 0) @(posedge i_clk);
        @(posedge i_clk);
        if (chk_last_ok) begin
            held_start.push_back(chk_last_page);
            held_count.push_back(cnt);
        end
    endtask

    task automatic free_held();
        int k;
        k = $urandom_range(held_start.size() - 1);
        send_beat(CMD_FREE, held_start[k], held_count[k]);
        held_start.delete(k);
        held_count.delete(k);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending > 0) @(posedge i_clk);
    endtask

    function automatic logic [10:0] rand_count();
        case ($urandom_range(9))
            0:       return 11'($urandom_range(2047));
            1:       return 11'($urandom_range(1024, 512));
            2:       return 11'd0;
            default: return 11'($urandom_range(16, 1));
        endcase
    endfunction

    initial begin
        int r;
        i_rst_n        = 1'b0;
        in_valid       = 1'b0;
        in_data        = '0;
        out_stall      = 1'b0;
        cycle_count    = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: whole pool, oversized, zero count, bad and misaligned frees
        alloc_tracked(11'd1024);
        send_beat(CMD_ALLOC, 10'h3ff, 11'd1);
        free_held();
        send_beat(CMD_FREE, 10'd0, 11'd1);
        send_beat(CMD_FREE, 10'd1023, 11'd2);
        send_beat(CMD_FREE, 10'd0, 11'd2047);
        send_beat(CMD_ALLOC, 10'd0, 11'd2047);
        alloc_tracked(11'd0);
        alloc_tracked(11'd3);
        alloc_tracked(11'd5);
        alloc_tracked(11'd512);
        send_beat(CMD_ALLOC, 10'd0, 11'd512);
        while (held_start.size() > 0) free_held();
        drain();
        alloc_tracked(11'd1024);
        send_beat(CMD_FREE, 10'd2, 11'd4);
        send_beat(CMD_FREE, 10'd6, 11'd2);
        send_beat(CMD_FREE, 10'd0, 11'd2);
        send_beat(CMD_FREE, 10'd1016, 11'd8);
        send_beat(CMD_FREE, 10'd3, 11'd1);
        send_beat(CMD_FREE, 10'h2aa, 11'h555);
        drain();

        // random phases; the drain after each one is the full pause
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
                default: begin send_idle_pct = 10; recv_stall_pct = 10; end
            endcase
            for (int i = 0; i < 55; i++) begin
                r = $urandom_range(99);
                if (r < 45) alloc_tracked(rand_count());
                else if (r < 85 && held_start.size() > 0) free_held();
                else send_beat(1'($urandom_range(1)), 10'($urandom), rand_count());
            end
            drain();
        end

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        drain();
        repeat (3000) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule

FILE: files.f
+incdir+rtl
rtl/bpa_pkg.sv
rtl/bpa_ram.sv
rtl/buddy_page_allocator.sv
tb/sv/buddy_page_allocator_checker.sv
tb/sv/buddy_page_allocator_tb.sv
